@@ sv/nonlinear_pid_valve_controller_core_assert.svh @@
// Assertion macros used by the sequencer RTL (npvc_ctrl).
`ifndef NONLINEAR_PID_VALVE_CONTROLLER_CORE_ASSERT_SVH
`define NONLINEAR_PID_VALVE_CONTROLLER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted.
`define NPVC_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("npvc assertion failed");
// Clocked check that also holds during reset.
`define NPVC_ASSERT_ANY(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("npvc assertion failed");
`else
`define NPVC_ASSERT_RST(lbl, clk, rst_n, prop)
`define NPVC_ASSERT_ANY(lbl, clk, prop)
`endif

`endif

@@ sv/npvc_pkg.sv @@
package npvc_pkg;

    // field widths
    localparam int SP_W    = 16;
    localparam int OLD_W   = 8;
    localparam int DRIVE_W = 7;
    localparam int REG_W   = 8;
    localparam int IDX_W   = 3;

    // datapath widths
    localparam int ERR_W   = 13;
    localparam int DLT_W   = 17;
    localparam int DIV_W   = 42;
    localparam int CNT_W   = 6;
    localparam int PROD_W  = 42;
    localparam int MA_W    = 32;
    localparam int MB_W    = 25;
    localparam int TERM_W  = 43;

    // constants of the control law
    localparam int ERR_LIMIT     = 4000;
    localparam int ISUM_LIMIT    = 12750;
    localparam int P_DIVISOR     = 100;
    localparam int OUT_LIMIT     = 50;

    // x / 100 as (x * P_RCP) >> P_RCP_SH, exact for x below 2^24
    localparam int P_RCP         = 21474837;
    localparam int P_RCP_SH      = 31;

    // register indexes
    localparam logic [IDX_W-1:0] REG_P_GAIN    = 3'd0;
    localparam logic [IDX_W-1:0] REG_I_GAIN    = 3'd1;
    localparam logic [IDX_W-1:0] REG_D_GAIN    = 3'd2;
    localparam logic [IDX_W-1:0] REG_SCALE     = 3'd3;
    localparam logic [IDX_W-1:0] REG_P_LIMIT   = 3'd4;
    localparam logic [IDX_W-1:0] REG_HOLD_BAND = 3'd5;

    // sequencer steps, also the datapath operation code
    typedef logic [4:0] t_state;
    localparam t_state ST_IDLE     = 5'd0;
    localparam t_state ST_ERR      = 5'd1;
    localparam t_state ST_PMAX     = 5'd2;
    localparam t_state ST_WSTEP    = 5'd3;
    localparam t_state ST_SUMADD   = 5'd4;
    localparam t_state ST_WSUMMAX  = 5'd5;
    localparam t_state ST_SUMCLAMP = 5'd6;
    localparam t_state ST_E2       = 5'd7;
    localparam t_state ST_PTERM    = 5'd9;
    localparam t_state ST_PCLAMP   = 5'd10;
    localparam t_state ST_IADD     = 5'd11;
    localparam t_state ST_DSQ      = 5'd12;
    localparam t_state ST_WD       = 5'd13;
    localparam t_state ST_DMUL     = 5'd14;
    localparam t_state ST_DADD     = 5'd15;
    localparam t_state ST_HOLD     = 5'd16;
    localparam t_state ST_WOUT     = 5'd17;
    localparam t_state ST_OUT      = 5'd18;

    typedef struct packed {
        t_state op;
        logic   in_take;
        logic   div_start;
        logic   out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_busy;
    } t_stat;

endpackage

@@ sv/npvc_if.sv @@
// Input word channel
interface npvc_in_if;
    logic                              valid;
    logic                              ready;
    logic                              opcode;
    logic signed [npvc_pkg::SP_W-1:0]  set_point;
    logic signed [npvc_pkg::SP_W-1:0]  measured;
    logic signed [npvc_pkg::OLD_W-1:0] prev_output;
    modport source(output valid, opcode, set_point, measured, prev_output, input ready);
    modport sink(input valid, opcode, set_point, measured, prev_output, output ready);
endinterface

// Result word channel
interface npvc_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [npvc_pkg::DRIVE_W-1:0] drive;
    modport source(output valid, drive, input ready);
    modport sink(input valid, drive, output ready);
endinterface

// Register write channel
interface npvc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [npvc_pkg::IDX_W-1:0]       index;
    logic [npvc_pkg::REG_W-1:0]       data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

@@ sv/nonlinear_pid_valve_controller_core.sv @@
// Channel  Dir  Fields                                        Word accepted when
// i_in     in   opcode, set_point, measured, prev_output      valid && ready
// o_out    out  drive                                         valid && ready
// i_cfg    in   index, data                                   valid && ready (always ready)
//
// A load word (opcode 1) is taken while the sequencer is idle and gives no result.
// A control step holds off the input until it returns to idle: four divisions on the
// shared radix-2 divider plus the other sequencer steps; the division by 100 is a
// reciprocal multiply. Its drive word is loaded into the output register in ST_OUT.
// Synchronous active-low reset restores the register defaults and clears state.
// A result waits in the output register; the next word is taken meanwhile,
// and its step stalls only at the end until that result is taken.
module nonlinear_pid_valve_controller_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    npvc_in_if.sink     i_in,
    npvc_out_if.source  o_out,
    npvc_cfg_if.sink    i_cfg
);
    npvc_pkg::t_cmd  cmd;
    npvc_pkg::t_stat stat;

    assign i_cfg.ready = 1'b1;

    npvc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_opcode (i_in.opcode),
        .i_stat      (stat),
        .o_in_ready  (i_in.ready),
        .o_cmd       (cmd)
    );

    npvc_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_opcode      (i_in.opcode),
        .i_set_point   (i_in.set_point),
        .i_measured    (i_in.measured),
        .i_prev_output (i_in.prev_output),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_drive       (o_out.drive)
    );
endmodule

@@ sv/npvc_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle
module npvc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [npvc_pkg::DIV_W-1:0]    i_dividend,
    input  logic [npvc_pkg::REG_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [npvc_pkg::DIV_W-1:0]    o_quotient
);
    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [npvc_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic [npvc_pkg::DIV_W-1:0]    r_quo, n_quo;
    logic [npvc_pkg::REG_W-1:0]    r_rem, n_rem;
    logic [npvc_pkg::REG_W-1:0]    r_dvs, n_dvs;
    logic [npvc_pkg::REG_W:0]      rem_sh;
    logic                          fits;

    // one shift/subtract step
    always_comb begin
        rem_sh = {r_rem, r_quo[npvc_pkg::DIV_W-1]};
        fits   = rem_sh >= {1'b0, r_dvs};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[npvc_pkg::DIV_W-2:0], fits};
            n_rem = fits ? npvc_pkg::REG_W'(rem_sh - {1'b0, r_dvs})
                         : rem_sh[npvc_pkg::REG_W-1:0];
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == npvc_pkg::CNT_W'(npvc_pkg::DIV_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

@@ sv/npvc_datapath.sv @@
// Registers, shared multiplier and divider of the control law
module npvc_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  npvc_pkg::t_cmd                       i_cmd,
    output npvc_pkg::t_stat                      o_stat,
    input  logic                                 i_opcode,
    input  logic signed [npvc_pkg::SP_W-1:0]     i_set_point,
    input  logic signed [npvc_pkg::SP_W-1:0]     i_measured,
    input  logic signed [npvc_pkg::OLD_W-1:0]    i_prev_output,
    input  logic                                 i_cfg_we,
    input  logic [npvc_pkg::IDX_W-1:0]           i_cfg_index,
    input  logic [npvc_pkg::REG_W-1:0]           i_cfg_data,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic signed [npvc_pkg::DRIVE_W-1:0]  o_drive
);
    localparam int SP_W   = npvc_pkg::SP_W;
    localparam int REG_W  = npvc_pkg::REG_W;
    localparam int ERR_W  = npvc_pkg::ERR_W;
    localparam int DLT_W  = npvc_pkg::DLT_W;
    localparam int DIV_W  = npvc_pkg::DIV_W;
    localparam int PROD_W = npvc_pkg::PROD_W;
    localparam int MA_W   = npvc_pkg::MA_W;
    localparam int MB_W   = npvc_pkg::MB_W;
    localparam int TERM_W = npvc_pkg::TERM_W;
    localparam int HD_W   = TERM_W + 1;
    localparam int OS_W   = npvc_pkg::OLD_W + REG_W + 1;

    localparam logic signed [DLT_W-1:0] ERR_HI = DLT_W'(npvc_pkg::ERR_LIMIT);
    localparam logic signed [DLT_W-1:0] ERR_LO = -DLT_W'(npvc_pkg::ERR_LIMIT);

    // configuration registers
    logic [REG_W-1:0] r_p_gain, r_i_gain, r_d_gain, r_scale, r_p_limit, r_hold_band;
    // input word and state
    logic signed [SP_W-1:0]             r_sp, r_pv, r_last, r_sum;
    logic signed [npvc_pkg::OLD_W-1:0]  r_old;
    // working registers
    logic signed [ERR_W-1:0]  r_err;
    logic signed [DLT_W-1:0]  r_dlt;
    logic [PROD_W-1:0]        r_prod;
    logic [SP_W-1:0]          r_pmax, r_step;
    logic [13:0]              r_summax;
    logic [MB_W-1:0]          r_e2;
    logic [MA_W-1:0]          r_dq;
    logic signed [TERM_W-1:0] r_term;
    logic                     r_hold;
    logic                     r_out_valid;
    logic signed [npvc_pkg::DRIVE_W-1:0] r_drive;

    logic [REG_W-1:0]          sc, pg, igd;
    logic [ERR_W-2:0]          err_mag;
    logic [SP_W-1:0]           dlt_mag;
    logic [SP_W-2:0]           sum_mag;
    logic signed [DLT_W-1:0]   diff, dlt_n;
    logic                      dir;
    logic [MA_W-1:0]           mul_a;
    logic [MB_W-1:0]           mul_b;
    logic [MA_W+MB_W-1:0]      mul_p;
    logic [DIV_W-1:0]          div_a;
    logic [REG_W-1:0]          div_b;
    logic                      div_done;
    logic [DIV_W-1:0]          div_q;
    logic [SP_W-1:0]           cl_mag;
    logic signed [SP_W:0]      sum_add;
    logic signed [TERM_W-1:0]  prod_s, pmin_s;
    logic [PROD_W-1:0]         pmin;
    logic signed [OS_W-1:0]    old_sc;
    logic signed [HD_W-1:0]    hdiff, hmag;
    logic [DIV_W-1:0]          term_mag;
    logic [DIV_W-1:0]          q_cl;
    logic signed [npvc_pkg::OLD_W-1:0] old_cl;
    logic signed [npvc_pkg::DRIVE_W-1:0] drive_n;

    // zero divisors count as one
    assign sc  = (r_scale  == '0) ? REG_W'(1) : r_scale;
    assign pg  = (r_p_gain == '0) ? REG_W'(1) : r_p_gain;
    assign igd = (r_i_gain == '0) ? REG_W'(1) : r_i_gain;

    assign err_mag = r_err[ERR_W-1] ? (ERR_W-1)'(-r_err) : r_err[ERR_W-2:0];
    assign dlt_mag = r_dlt[DLT_W-1] ? SP_W'(-r_dlt) : r_dlt[SP_W-1:0];
    assign sum_mag = r_sum[SP_W-1] ? (SP_W-1)'(-r_sum) : r_sum[SP_W-2:0];
    assign dir = (r_dlt > 0 && r_err > 0) || (r_dlt < 0 && r_err < 0);

    // error and measurement change
    always_comb begin
        diff  = $signed({r_sp[SP_W-1], r_sp}) - $signed({r_pv[SP_W-1], r_pv});
        dlt_n = $signed({r_last[SP_W-1], r_last}) - $signed({r_pv[SP_W-1], r_pv});
        if (diff > ERR_HI)      diff = ERR_HI;
        else if (diff < ERR_LO) diff = ERR_LO;
    end

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            npvc_pkg::ST_ERR: begin
                mul_a = MA_W'(sc);
                mul_b = MB_W'(r_p_limit);
            end
            npvc_pkg::ST_SUMCLAMP: begin
                mul_a = MA_W'(err_mag);
                mul_b = MB_W'(err_mag);
            end
            // squared error divided by 100 through its reciprocal
            npvc_pkg::ST_E2: begin
                mul_a = MA_W'(r_prod);
                mul_b = MB_W'(npvc_pkg::P_RCP);
            end
            npvc_pkg::ST_PTERM: begin
                mul_a = MA_W'(r_e2);
                mul_b = MB_W'(r_p_gain);
            end
            npvc_pkg::ST_PCLAMP: begin
                mul_a = MA_W'(sum_mag);
                mul_b = MB_W'(r_i_gain);
            end
            npvc_pkg::ST_IADD: begin
                mul_a = MA_W'(dlt_mag);
                mul_b = MB_W'(dlt_mag);
            end
            npvc_pkg::ST_DMUL: begin
                mul_a = r_dq;
                mul_b = MB_W'(r_d_gain);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    assign term_mag = r_term[TERM_W-1] ? DIV_W'(-r_term) : DIV_W'(r_term);

    // divider operands
    always_comb begin
        div_a = r_prod;
        div_b = sc;
        case (i_cmd.op)
            npvc_pkg::ST_PMAX:   div_b = pg;
            npvc_pkg::ST_SUMADD: begin
                div_a = DIV_W'(sc) * DIV_W'(npvc_pkg::OUT_LIMIT);
                div_b = igd;
            end
            npvc_pkg::ST_HOLD:   div_a = term_mag;
            default:             div_b = sc;
        endcase
    end

    npvc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // step, term and hold arithmetic
    always_comb begin
        cl_mag  = (SP_W'(err_mag) > r_step) ? r_step : SP_W'(err_mag);
        sum_add = r_err[ERR_W-1] ? $signed({r_sum[SP_W-1], r_sum}) - $signed({1'b0, cl_mag})
                                 : $signed({r_sum[SP_W-1], r_sum}) + $signed({1'b0, cl_mag});
        prod_s  = $signed({1'b0, r_prod});
        pmin    = (r_prod > PROD_W'(r_pmax)) ? PROD_W'(r_pmax) : r_prod;
        pmin_s  = $signed({1'b0, pmin});
        old_sc  = OS_W'(r_old) * $signed({1'b0, sc});
        hdiff   = HD_W'(r_term) - HD_W'(old_sc);
        hmag    = hdiff[HD_W-1] ? -hdiff : hdiff;
        q_cl    = (div_q > DIV_W'(npvc_pkg::OUT_LIMIT)) ? DIV_W'(npvc_pkg::OUT_LIMIT) : div_q;
        if (r_old > npvc_pkg::OLD_W'(npvc_pkg::OUT_LIMIT))
            old_cl = npvc_pkg::OLD_W'(npvc_pkg::OUT_LIMIT);
        else if (r_old < -npvc_pkg::OLD_W'(npvc_pkg::OUT_LIMIT))
            old_cl = -npvc_pkg::OLD_W'(npvc_pkg::OUT_LIMIT);
        else
            old_cl = r_old;
        if (r_hold)
            drive_n = old_cl[npvc_pkg::DRIVE_W-1:0];
        else if (r_term[TERM_W-1])
            drive_n = -$signed(q_cl[npvc_pkg::DRIVE_W-1:0]);
        else
            drive_n = $signed(q_cl[npvc_pkg::DRIVE_W-1:0]);
    end

    // configuration, state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_gain    <= REG_W'(1);
            r_i_gain    <= '0;
            r_d_gain    <= '0;
            r_scale     <= REG_W'(1);
            r_p_limit   <= REG_W'(npvc_pkg::OUT_LIMIT);
            r_hold_band <= '0;
            r_last      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    npvc_pkg::REG_P_GAIN:    r_p_gain    <= i_cfg_data;
                    npvc_pkg::REG_I_GAIN:    r_i_gain    <= i_cfg_data;
                    npvc_pkg::REG_D_GAIN:    r_d_gain    <= i_cfg_data;
                    npvc_pkg::REG_SCALE:     r_scale     <= i_cfg_data;
                    npvc_pkg::REG_P_LIMIT:   r_p_limit   <= i_cfg_data;
                    npvc_pkg::REG_HOLD_BAND: r_hold_band <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.in_take && i_opcode)
                r_last <= i_measured;
            else if (i_cmd.op == npvc_pkg::ST_ERR)
                r_last <= r_pv;
            if (i_cmd.op == npvc_pkg::ST_SUMADD && dir)
                r_sum <= sum_add[SP_W-1:0];
            else if (i_cmd.op == npvc_pkg::ST_SUMCLAMP) begin
                if (r_sum > $signed({2'b00, r_summax}))
                    r_sum <= $signed({2'b00, r_summax});
                else if (r_sum < -$signed({2'b00, r_summax}))
                    r_sum <= -$signed({2'b00, r_summax});
            end
            if (i_cmd.out_load)
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p[PROD_W-1:0];
        if (i_cmd.in_take) begin
            r_sp  <= i_set_point;
            r_pv  <= i_measured;
            r_old <= i_prev_output;
        end
        if (i_cmd.out_load)
            r_drive <= drive_n;
        case (i_cmd.op)
            npvc_pkg::ST_ERR: begin
                r_err <= diff[ERR_W-1:0];
                r_dlt <= dlt_n;
            end
            npvc_pkg::ST_PMAX:    r_pmax <= r_prod[SP_W-1:0];
            npvc_pkg::ST_WSTEP:   if (div_done) r_step <= div_q[SP_W-1:0];
            npvc_pkg::ST_WSUMMAX: begin
                if (div_done)
                    r_summax <= (r_i_gain == '0) ? 14'(npvc_pkg::ISUM_LIMIT) : div_q[13:0];
            end
            npvc_pkg::ST_E2:      r_e2 <= mul_p[npvc_pkg::P_RCP_SH +: MB_W];
            npvc_pkg::ST_PCLAMP:  r_term <= r_err[ERR_W-1] ? -pmin_s : pmin_s;
            npvc_pkg::ST_IADD:    r_term <= r_sum[SP_W-1] ? r_term - prod_s : r_term + prod_s;
            npvc_pkg::ST_WD:      if (div_done) r_dq <= div_q[MA_W-1:0];
            npvc_pkg::ST_DADD:    r_term <= r_dlt[DLT_W-1] ? r_term - prod_s : r_term + prod_s;
            npvc_pkg::ST_HOLD:    r_hold <= hmag < $signed({{(HD_W-REG_W){1'b0}}, r_hold_band});
            default: ;
        endcase
    end

    assign o_stat.div_done = div_done;
    assign o_stat.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_drive         = r_drive;
endmodule

@@ sv/npvc_ctrl.sv @@
// Sequencer of the control step
module npvc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_opcode,
    input  npvc_pkg::t_stat  i_stat,
    output logic             o_in_ready,
    output npvc_pkg::t_cmd   o_cmd
);
    `include "nonlinear_pid_valve_controller_core_assert.svh"

    npvc_pkg::t_state r_state, n_state;
    logic             take;

    assign o_in_ready = (r_state == npvc_pkg::ST_IDLE);
    assign take       = i_in_valid && o_in_ready;

    // next step
    always_comb begin
        n_state = r_state;
        case (r_state)
            npvc_pkg::ST_IDLE:     if (take && !i_in_opcode) n_state = npvc_pkg::ST_ERR;
            npvc_pkg::ST_ERR:      n_state = npvc_pkg::ST_PMAX;
            npvc_pkg::ST_PMAX:     n_state = npvc_pkg::ST_WSTEP;
            npvc_pkg::ST_WSTEP:    if (i_stat.div_done) n_state = npvc_pkg::ST_SUMADD;
            npvc_pkg::ST_SUMADD:   n_state = npvc_pkg::ST_WSUMMAX;
            npvc_pkg::ST_WSUMMAX:  if (i_stat.div_done) n_state = npvc_pkg::ST_SUMCLAMP;
            npvc_pkg::ST_SUMCLAMP: n_state = npvc_pkg::ST_E2;
            npvc_pkg::ST_E2:       n_state = npvc_pkg::ST_PTERM;
            npvc_pkg::ST_PTERM:    n_state = npvc_pkg::ST_PCLAMP;
            npvc_pkg::ST_PCLAMP:   n_state = npvc_pkg::ST_IADD;
            npvc_pkg::ST_IADD:     n_state = npvc_pkg::ST_DSQ;
            npvc_pkg::ST_DSQ:      n_state = npvc_pkg::ST_WD;
            npvc_pkg::ST_WD:       if (i_stat.div_done) n_state = npvc_pkg::ST_DMUL;
            npvc_pkg::ST_DMUL:     n_state = npvc_pkg::ST_DADD;
            npvc_pkg::ST_DADD:     n_state = npvc_pkg::ST_HOLD;
            npvc_pkg::ST_HOLD:     n_state = npvc_pkg::ST_WOUT;
            npvc_pkg::ST_WOUT:     if (i_stat.div_done) n_state = npvc_pkg::ST_OUT;
            npvc_pkg::ST_OUT:      if (!i_stat.out_busy) n_state = npvc_pkg::ST_IDLE;
            default:               n_state = npvc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= npvc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // commands
    assign o_cmd.op        = r_state;
    assign o_cmd.in_take   = take;
    assign o_cmd.div_start = (r_state == npvc_pkg::ST_PMAX) || (r_state == npvc_pkg::ST_SUMADD)
                          || (r_state == npvc_pkg::ST_DSQ) || (r_state == npvc_pkg::ST_HOLD);
    assign o_cmd.out_load  = (r_state == npvc_pkg::ST_OUT) && !i_stat.out_busy;

    `NPVC_ASSERT_RST(a_step_starts, i_clk, i_rst_n, (take && !i_in_opcode) |=> (r_state == npvc_pkg::ST_ERR))
    `NPVC_ASSERT_ANY(a_load_in_out, i_clk, o_cmd.out_load |-> (r_state == npvc_pkg::ST_OUT))
    `NPVC_ASSERT_RST(a_final_div, i_clk, i_rst_n, (r_state == npvc_pkg::ST_WOUT && i_stat.div_done) |=> (r_state == npvc_pkg::ST_OUT))
endmodule
